>>> src/eyevs_pkg.sv
// shared types and constants of the eye vote sleep detector
// beat structs, eye and sleep codes, register indexes and widths; no dependencies
package eyevs_pkg;

    localparam int TIME_BITS = 32;
    localparam int TS_W      = 32;
    localparam int VOTE_W    = 7;
    localparam int LIMIT_W   = 6;
    localparam int SLEEP_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_VOTE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_TIME = 2'd1;

    localparam logic [LIMIT_W-1:0] VOTE_LIMIT_RST = 6'd5;
    localparam logic [SLEEP_W-1:0] SLEEP_TIME_RST = 16'd3000;

    typedef enum logic [1:0] {
        EYE_CLOSED = 2'd0,
        EYE_OPEN   = 2'd1,
        EYE_NA     = 2'd2
    } eye_state_t;

    typedef enum logic [1:0] {
        SLEEP_AWAKE  = 2'd0,
        SLEEP_ASLEEP = 2'd1,
        SLEEP_NODET  = 2'd2
    } sleep_status_t;

    typedef struct packed {
        logic            left_present;
        logic [1:0]      left_label;
        logic            right_present;
        logic [1:0]      right_label;
        logic [TS_W-1:0] time_ms;
    } eyevs_in_t;

    typedef struct packed {
        logic [1:0] left_state;
        logic [1:0] right_state;
        logic [1:0] sleep_status;
    } eyevs_out_t;

endpackage

>>> src/eyevs_vote.sv
// vote counters and filtered state of one eye
// three saturating counters, argmax with lower index on ties; uses eyevs_pkg
module eyevs_vote (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          present,
    input  logic [1:0]                    label,
    input  logic [eyevs_pkg::LIMIT_W-1:0] vote_limit,
    output eyevs_pkg::eye_state_t         state
);
    import eyevs_pkg::*;

    localparam int SUM_W = VOTE_W + 1;

    logic signed [VOTE_W-1:0] votes_reg  [3];
    logic signed [VOTE_W-1:0] votes_next [3];
    logic [1:0]               win;
    logic [1:0]               best;

    assign win = (label == 2'd3) ? 2'd2 : label;

    always_comb begin
        logic signed [SUM_W-1:0] lim;
        logic signed [SUM_W-1:0] nlim;
        logic signed [SUM_W-1:0] sum;
        lim  = {{(SUM_W-LIMIT_W){1'b0}}, vote_limit};
        nlim = -lim;
        sum  = '0;
        for (int k = 0; k < 3; k++) begin
            votes_next[k] = votes_reg[k];
            if (present) begin
                if (2'(k) == win) begin
                    sum = {votes_reg[k][VOTE_W-1], votes_reg[k]} + SUM_W'(1);
                    votes_next[k] = (sum >= lim) ? lim[VOTE_W-1:0] : sum[VOTE_W-1:0];
                end else begin
                    sum = {votes_reg[k][VOTE_W-1], votes_reg[k]} - SUM_W'(1);
                    votes_next[k] = (sum <= nlim) ? nlim[VOTE_W-1:0] : sum[VOTE_W-1:0];
                end
            end
        end
    end

    // argmax, lower index wins ties
    always_comb begin
        best = 2'd0;
        if (votes_next[1] > votes_next[0]) begin
            best = 2'd1;
        end
        if (votes_next[2] > votes_next[best]) begin
            best = 2'd2;
        end
    end

    assign state = eye_state_t'(best);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                votes_reg[k] <= '0;
            end
        end else if (en) begin
            for (int k = 0; k < 3; k++) begin
                votes_reg[k] <= votes_next[k];
            end
        end
    end

endmodule

>>> src/eyevs_sleep_timer.sv
// closure timer and sleep status decision
// takes both filtered eye states and the frame time; uses eyevs_pkg
module eyevs_sleep_timer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  eyevs_pkg::eye_state_t           left_state,
    input  eyevs_pkg::eye_state_t           right_state,
    input  logic [eyevs_pkg::TIME_BITS-1:0] now,
    input  logic [eyevs_pkg::SLEEP_W-1:0]   sleep_time,
    output eyevs_pkg::sleep_status_t        status
);
    import eyevs_pkg::*;

    logic [TIME_BITS-1:0] closure_start_reg, closure_start_next;
    logic                 not_yet_closed_reg, not_yet_closed_next;
    sleep_status_t        sleep_state_reg, sleep_state_next;
    logic [TIME_BITS-1:0] start;
    logic [TIME_BITS-1:0] elapsed;

    assign start   = not_yet_closed_reg ? now : closure_start_reg;
    assign elapsed = now - start;

    always_comb begin
        closure_start_next  = closure_start_reg;
        not_yet_closed_next = not_yet_closed_reg;
        sleep_state_next    = sleep_state_reg;
        if (left_state == EYE_CLOSED && right_state == EYE_CLOSED) begin
            closure_start_next  = start;
            not_yet_closed_next = 1'b0;
            if (elapsed > TIME_BITS'(sleep_time)) begin
                sleep_state_next = SLEEP_ASLEEP;
            end
        end else if (left_state == EYE_OPEN && right_state == EYE_OPEN) begin
            sleep_state_next    = SLEEP_AWAKE;
            not_yet_closed_next = 1'b1;
        end else if (left_state == EYE_NA || right_state == EYE_NA) begin
            sleep_state_next    = SLEEP_NODET;
            not_yet_closed_next = 1'b1;
        end
    end

    assign status = sleep_state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            closure_start_reg  <= '0;
            not_yet_closed_reg <= 1'b1;
            sleep_state_reg    <= SLEEP_AWAKE;
        end else if (en) begin
            closure_start_reg  <= closure_start_next;
            not_yet_closed_reg <= not_yet_closed_next;
            sleep_state_reg    <= sleep_state_next;
        end
    end

endmodule

>>> src/eye_vote_sleep_detector_core.sv
// Eye vote sleep detector: one frame beat in, one status beat out. A frame is
// taken every cycle while m_ready is high. Each frame is held in the input
// register and its result in the result register, which drives m_data;
// the vote counters and closure timer update at the edge that moves
// the frame from the input register to the result register. With the result
// register held by a low m_ready, one more frame waits in the input register and
// s_ready then drops. Configuration writes are always accepted and should only
// be issued while the block is idle.
// Depends on eyevs_pkg, eyevs_vote and eyevs_sleep_timer.
module eye_vote_sleep_detector_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  eyevs_pkg::eyevs_in_t             s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output eyevs_pkg::eyevs_out_t            m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [eyevs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [eyevs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import eyevs_pkg::*;

    eyevs_in_t            in_data_reg;
    logic                 in_vld_reg;
    eyevs_out_t           out_data_reg;
    logic                 out_vld_reg;
    logic [LIMIT_W-1:0]   vote_limit_reg;
    logic [SLEEP_W-1:0]   sleep_time_reg;
    logic                 adv;
    eye_state_t           left_state;
    eye_state_t           right_state;
    sleep_status_t        status;
    logic [TIME_BITS-1:0] now;

    assign adv       = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready   = !in_vld_reg || adv;
    assign m_valid   = out_vld_reg;
    assign m_data    = out_data_reg;
    assign cfg_ready = 1'b1;
    assign now       = TIME_BITS'(in_data_reg.time_ms);

    eyevs_vote u_left (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (adv),
        .present    (in_data_reg.left_present),
        .label      (in_data_reg.left_label),
        .vote_limit (vote_limit_reg),
        .state      (left_state)
    );

    eyevs_vote u_right (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (adv),
        .present    (in_data_reg.right_present),
        .label      (in_data_reg.right_label),
        .vote_limit (vote_limit_reg),
        .state      (right_state)
    );

    eyevs_sleep_timer u_timer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (adv),
        .left_state  (left_state),
        .right_state (right_state),
        .now         (now),
        .sleep_time  (sleep_time_reg),
        .status      (status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_vld_reg <= 1'b1;
            end else if (adv) begin
                in_vld_reg <= 1'b0;
            end
            if (adv) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (adv) begin
            out_data_reg.left_state   <= left_state;
            out_data_reg.right_state  <= right_state;
            out_data_reg.sleep_status <= status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vote_limit_reg <= VOTE_LIMIT_RST;
            sleep_time_reg <= SLEEP_TIME_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_VOTE_LIMIT: vote_limit_reg <= cfg_data[LIMIT_W-1:0];
                CFG_SLEEP_TIME: sleep_time_reg <= cfg_data[SLEEP_W-1:0];
                default: ;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // both eyes open always resolves to awake
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && out_data_reg.left_state == EYE_OPEN
                     && out_data_reg.right_state == EYE_OPEN)
        |-> (out_data_reg.sleep_status == SLEEP_AWAKE))
        else $error("open eyes without awake status");

    // an na eye always resolves to no detection
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && (out_data_reg.left_state == EYE_NA
                      || out_data_reg.right_state == EYE_NA))
        |-> (out_data_reg.sleep_status == SLEEP_NODET))
        else $error("na eye without no-detection status");

    // a held frame beat is not dropped while the result side stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && !adv) |=> (in_vld_reg && $stable(in_data_reg)))
        else $error("stalled frame beat lost");

    // a result beat is produced exactly when a frame leaves the input register
    assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> out_vld_reg)
        else $error("frame advanced without result beat");
`endif

endmodule
